>>> sv/lzss_unit_decompressor_macros.svh
`ifndef LZSS_UNIT_DECOMPRESSOR_MACROS_SVH
`define LZSS_UNIT_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LZSSUD_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lzssud: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define LZSSUD_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lzssud: next-cycle check failed");

`endif

>>> sv/lzssud_pkg.sv
package lzssud_pkg;

  localparam int DIST_W     = 14;
  localparam int CNT_W      = 7;
  localparam int OLEN_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CMDQ_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIAS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
    logic       input_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       run_last;
    logic       stream_end;
    logic       bad_reference;
  } out_t;

  typedef struct packed {
    logic [2:0]        unit_bytes;
    logic [1:0]        length_bias;
    logic [OLEN_W-1:0] output_length;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LIT   = 2'd1,
    KIND_MATCH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] offset;
    logic [OLEN_W-1:0] base;
    logic              ending;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    cmd_t head;
  } cmdq_status_t;

endpackage

>>> sv/lzss_unit_decompressor.sv
// Streaming LZSS decoder: one compressed byte per input transaction, one
// decompressed byte (or an end marker) per output transaction. The front end
// takes a compressed byte every cycle while its four-entry command queue has
// room; flag and low token bytes queue nothing unless they end the stream. The
// back end owns the single-port-per-direction history memory and emits at most
// one byte per cycle unless the output stalls: a literal goes out from idle; a
// match starts the history read in idle, then emits its bytes in the copy
// state, so the history read/write loop sets the sustained rate. Output
// backpressure stalls the back end; the queue keeps the front end running until
// it fills. History memory is not cleared after reset and needs no warm-up.
module lzss_unit_decompressor import lzssud_pkg::*; #(
  parameter int HISTORY_DEPTH = 16384,
  parameter int MAX_RUN       = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t         cfg;
  logic         push;
  cmd_t         push_cmd;
  logic         pop;
  cmdq_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_bytes    <= 3'd1;
      cfg.length_bias   <= 2'd2;
      cfg.output_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_BYTES:    cfg.unit_bytes    <= cfg_data[2:0];
        CFG_LENGTH_BIAS:   cfg.length_bias   <= cfg_data[1:0];
        CFG_OUTPUT_LENGTH: cfg.output_length <= cfg_data[OLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lzssud_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_status.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lzssud_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .status   (q_status)
  );

  lzssud_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sv/lzssud_ram.sv
module lzssud_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lzssud_cmdq.sv
module lzssud_cmdq import lzssud_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmdq_status_t status
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t         entries [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == (PW+1)'(CMDQ_DEPTH));
  assign status.head  = entries[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

>>> sv/lzssud_front.sv
module lzssud_front import lzssud_pkg::*; #(
  parameter int MAX_RUN = 64
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  input  logic q_full,
  output logic push,
  output cmd_t push_cmd
);

  typedef enum logic [3:0] {
    PH_FLAG = 4'b0001,
    PH_LIT  = 4'b0010,
    PH_TLO  = 4'b0100,
    PH_THI  = 4'b1000
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [3:0]        bit_index;
  logic [3:0]        bit_index_next;
  logic [7:0]        flag_bits;
  logic [7:0]        flag_bits_next;
  logic [2:0]        literal_left;
  logic [2:0]        literal_left_next;
  logic [7:0]        token_low;
  logic [7:0]        token_low_next;
  logic              closed;
  logic              closed_next;
  logic [OLEN_W-1:0] produced;
  logic [OLEN_W-1:0] produced_next;

  logic              accept;
  logic              ignore;
  logic              ending;
  logic [2:0]        unit;
  phase_t            ph0;
  logic [3:0]        bit0;
  logic [2:0]        lit0;
  logic [OLEN_W-1:0] p0;
  logic [2:0]        lit_dec;
  logic [3:0]        bit_adv;
  logic [15:0]       tok;
  logic [DIST_W-1:0] offset;
  logic [4:0]        len_code;
  logic [CNT_W-1:0]  len_raw;
  logic [CNT_W-1:0]  len_clip;
  logic [OLEN_W-1:0] remaining;
  logic [CNT_W-1:0]  n;

  function automatic phase_t select_phase(input logic [3:0] bi, input logic [7:0] fl);
    phase_t p;
    if (bi[3]) begin
      p = PH_FLAG;
    end else if (fl[bi[2:0]]) begin
      p = PH_LIT;
    end else begin
      p = PH_TLO;
    end
    return p;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (cfg.unit_bytes == 3'd0) begin
      unit = 3'd1;
    end else if (cfg.unit_bytes > 3'd4) begin
      unit = 3'd4;
    end else begin
      unit = cfg.unit_bytes;
    end
  end

  assign ph0  = in_data.stream_start ? PH_FLAG : phase;
  assign bit0 = in_data.stream_start ? 4'd8 : bit_index;
  assign lit0 = in_data.stream_start ? 3'd0 : literal_left;
  assign p0   = in_data.stream_start ? '0 : produced;

  assign ignore = !in_data.stream_start && (closed || produced >= cfg.output_length);

  assign lit_dec   = (lit0 != 3'd0) ? lit0 - 3'd1 : 3'd0;
  assign bit_adv   = bit0 + 4'd1;
  assign tok       = {in_data.in_byte, token_low};
  assign offset    = {2'b0, tok[15:4]} * {11'b0, unit};
  assign len_code  = {1'b0, tok[3:0]} + {3'b0, cfg.length_bias};
  assign len_raw   = {2'b0, len_code} * {4'b0, unit};
  assign len_clip  = (len_raw > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : len_raw;
  assign remaining = cfg.output_length - p0;

  always_comb begin
    phase_next        = ph0;
    bit_index_next    = bit0;
    flag_bits_next    = flag_bits;
    literal_left_next = lit0;
    token_low_next    = token_low;
    n                 = '0;
    if (p0 < cfg.output_length) begin
      unique case (ph0)
        PH_FLAG: begin
          flag_bits_next = in_data.in_byte;
          bit_index_next = 4'd0;
          phase_next     = select_phase(4'd0, in_data.in_byte);
          if (phase_next == PH_LIT) begin
            literal_left_next = unit;
          end
        end
        PH_LIT: begin
          n                 = CNT_W'(1);
          literal_left_next = lit_dec;
          if (lit_dec == 3'd0) begin
            bit_index_next = bit_adv;
            phase_next     = select_phase(bit_adv, flag_bits);
            if (phase_next == PH_LIT) begin
              literal_left_next = unit;
            end
          end
        end
        PH_TLO: begin
          token_low_next = in_data.in_byte;
          phase_next     = PH_THI;
        end
        PH_THI: begin
          n = ({{(OLEN_W-CNT_W){1'b0}}, len_clip} > remaining)
              ? remaining[CNT_W-1:0] : len_clip;
          bit_index_next = bit_adv;
          phase_next     = select_phase(bit_adv, flag_bits);
          if (phase_next == PH_LIT) begin
            literal_left_next = unit;
          end
        end
        default: begin
          phase_next = PH_FLAG;
        end
      endcase
    end
  end

  assign produced_next = p0 + {{(OLEN_W-CNT_W){1'b0}}, n};
  assign closed_next   = (!in_data.stream_start && closed) || in_data.input_last;
  assign ending        = in_data.input_last || produced_next >= cfg.output_length;

  assign push = accept && !ignore && (n != '0 || ending);

  always_comb begin
    push_cmd.data   = in_data.in_byte;
    push_cmd.count  = n;
    push_cmd.offset = offset;
    push_cmd.base   = p0;
    push_cmd.ending = ending;
    if (n == '0) begin
      push_cmd.kind = KIND_NONE;
    end else if (ph0 == PH_LIT) begin
      push_cmd.kind = KIND_LIT;
    end else begin
      push_cmd.kind = KIND_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      flag_bits <= flag_bits_next;
      token_low <= token_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAG;
      bit_index    <= 4'd8;
      literal_left <= 3'd0;
      closed       <= 1'b0;
      produced     <= '0;
    end else if (accept && !ignore) begin
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      literal_left <= literal_left_next;
      closed       <= closed_next;
      produced     <= produced_next;
    end
  end

endmodule

>>> sv/lzssud_back.sv
module lzssud_back import lzssud_pkg::*; #(
  parameter int HISTORY_DEPTH = 16384
) (
  input  logic         clk,
  input  logic         rst,
  input  cmdq_status_t q_status,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output out_t         out_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int DW = ((AW > DIST_W) ? AW : DIST_W) + 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_COPY = 2'b10
  } bstate_t;

  bstate_t           state;
  bstate_t           state_next;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] dist_q_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [OLEN_W-1:0] prod;
  logic [OLEN_W-1:0] prod_next;
  logic              ending_q;
  logic              ending_q_next;
  logic [AW-1:0]     wp;
  logic [AW-1:0]     wp_next;
  logic [7:0]        last_byte;
  logic [7:0]        last_byte_next;

  logic              can_load;
  logic              load;
  out_t              load_data;
  logic              fire_copy;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     abase;
  logic [DIST_W-1:0] dsel;
  logic [DW-1:0]     diff;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;
  logic              we;
  logic [7:0]        wdata;
  logic              bad;
  logic [7:0]        copy_byte;
  cmd_t              head;

  assign head      = q_status.head;
  assign can_load  = !out_valid || !out_stall;
  assign fire_copy = (state == B_COPY) && can_load;
  assign wp_inc    = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + AW'(1);

  // Read address for the next byte to emit; the history memory registers the read.
  assign dsel    = (state == B_COPY) ? dist_q : head.offset;
  assign abase   = fire_copy ? wp_inc : wp;
  assign diff    = DW'(abase) - DW'(dsel);
  assign rd_addr = diff[DW-1] ? AW'(diff + DW'(HISTORY_DEPTH)) : AW'(diff);

  assign bad = (dist_q == '0)
            || ({{(OLEN_W-DIST_W){1'b0}}, dist_q} > prod)
            || (32'(dist_q) > 32'(HISTORY_DEPTH));

  // Distance one repeats the byte just written; bypass the memory.
  assign copy_byte = bad ? 8'd0 : ((dist_q == DIST_W'(1)) ? last_byte : rd_data);

  lzssud_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next     = state;
    dist_q_next    = dist_q;
    cnt_next       = cnt;
    prod_next      = prod;
    ending_q_next  = ending_q;
    wp_next        = wp;
    last_byte_next = last_byte;
    pop            = 1'b0;
    we             = 1'b0;
    wdata          = head.data;
    load           = 1'b0;
    load_data      = '0;
    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          unique case (head.kind)
            KIND_LIT: begin
              if (can_load) begin
                pop                     = 1'b1;
                we                      = 1'b1;
                load                    = 1'b1;
                load_data.out_byte      = head.data;
                load_data.has_data      = 1'b1;
                load_data.run_last      = 1'b1;
                load_data.stream_end    = head.ending;
                wp_next                 = wp_inc;
                last_byte_next          = head.data;
              end
            end
            KIND_MATCH: begin
              pop           = 1'b1;
              dist_q_next   = head.offset;
              cnt_next      = head.count;
              prod_next     = head.base;
              ending_q_next = head.ending;
              state_next    = B_COPY;
            end
            default: begin
              if (can_load) begin
                pop                  = 1'b1;
                load                 = 1'b1;
                load_data.run_last   = 1'b1;
                load_data.stream_end = head.ending;
              end
            end
          endcase
        end
      end
      B_COPY: begin
        wdata = copy_byte;
        if (can_load) begin
          we                      = 1'b1;
          load                    = 1'b1;
          load_data.out_byte      = copy_byte;
          load_data.has_data      = 1'b1;
          load_data.run_last      = (cnt == CNT_W'(1));
          load_data.stream_end    = (cnt == CNT_W'(1)) && ending_q;
          load_data.bad_reference = bad;
          wp_next                 = wp_inc;
          last_byte_next          = copy_byte;
          prod_next               = prod + OLEN_W'(1);
          cnt_next                = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state_next = B_IDLE;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dist_q    <= dist_q_next;
    cnt       <= cnt_next;
    prod      <= prod_next;
    ending_q  <= ending_q_next;
    last_byte <= last_byte_next;
    if (can_load && load) begin
      out_data <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      if (can_load) begin
        out_valid <= load;
      end
    end
  end

endmodule

>>> sv/lzssud_checker.sv
`include "lzss_unit_decompressor_macros.svh"

module lzssud_checker import lzssud_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `LZSSUD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `LZSSUD_ASSERT_NEXT(a_run_continues, clk, rst, out_valid && !out_stall && !out_data.run_last, out_valid)
  `LZSSUD_ASSERT_IMPLY(a_empty_ends, clk, rst, out_valid && !out_data.has_data, out_data.run_last && out_data.stream_end && out_data.out_byte == 8'd0 && !out_data.bad_reference)
  `LZSSUD_ASSERT_IMPLY(a_bad_zero, clk, rst, out_valid && out_data.bad_reference, out_data.has_data && out_data.out_byte == 8'd0)

endmodule

bind lzss_unit_decompressor lzssud_checker u_checker (.*);

>>> tb/sv/tb_lzss_unit_decompressor.sv
module tb_lzss_unit_decompressor;
  import lzssud_pkg::*;

  localparam int HIST_DEPTH = 16384;
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int RUN_MAX = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [23:0] OLEN_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    AWAIT_FLAG,
    IN_LITERAL,
    AWAIT_TOKEN_LO,
    AWAIT_TOKEN_HI
  } dec_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lzss_unit_decompressor #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .MAX_RUN(RUN_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder mirror
  logic [7:0] hist [HIST_DEPTH];
  int unsigned wpos;
  int unsigned produced;
  logic [7:0] flags;
  int unsigned bit_idx;
  dec_phase_t dphase;
  int unsigned lit_left;
  logic [7:0] tok_lo;
  bit closed;
  logic [2:0] cfg_unit;
  logic [1:0] cfg_bias;
  logic [23:0] cfg_olen;

  out_t pending_out [$];
  int unsigned n_emit;
  bit ignored_hit;
  int unsigned taken_items;
  int unsigned fail_count;
  int cycle_count;
  bit idle_on;
  int unsigned hold_req = 0;
  out_t want_out;

  function automatic int unsigned unit_of(input logic [2:0] u);
    if (u == 3'd0) return 1;
    if (u > 3'd4) return 4;
    return {29'd0, u};
  endfunction

  function automatic void pick_element();
    if (bit_idx >= 8) begin
      dphase = AWAIT_FLAG;
    end else if (flags[bit_idx[2:0]]) begin
      dphase = IN_LITERAL;
      lit_left = unit_of(cfg_unit);
    end else begin
      dphase = AWAIT_TOKEN_LO;
    end
  endfunction

  function automatic void store_out(input logic [7:0] b, input logic bad);
    out_t r;
    r.out_byte = b;
    r.has_data = 1'b1;
    r.run_last = 1'b0;
    r.stream_end = 1'b0;
    r.bad_reference = bad;
    pending_out.push_back(r);
    hist[wpos[HIST_AW-1:0]] = b;
    wpos = (wpos + 1) % HIST_DEPTH;
    produced++;
    n_emit++;
  endfunction

  function automatic void decode_byte(input in_t it);
    int unsigned tok, u, span, run, i, idx;
    bit ending;
    out_t r;
    n_emit = 0;
    ignored_hit = 1'b0;
    if (it.stream_start) begin
      produced = 0;
      closed = 1'b0;
      dphase = AWAIT_FLAG;
      bit_idx = 8;
      lit_left = 0;
    end else if (closed || produced >= cfg_olen) begin
      ignored_hit = 1'b1;
      return;
    end
    if (produced < cfg_olen) begin
      case (dphase)
        AWAIT_FLAG: begin
          flags = it.in_byte;
          bit_idx = 0;
          pick_element();
        end
        IN_LITERAL: begin
          store_out(it.in_byte, 1'b0);
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) begin
            bit_idx++;
            pick_element();
          end
        end
        AWAIT_TOKEN_LO: begin
          tok_lo = it.in_byte;
          dphase = AWAIT_TOKEN_HI;
        end
        default: begin
          tok = {16'd0, it.in_byte, tok_lo};
          u = unit_of(cfg_unit);
          span = (tok >> 4) * u;
          run = ((tok & 32'h0f) + cfg_bias) * u;
          if (run > RUN_MAX) run = RUN_MAX;
          for (i = 0; i < run && produced < cfg_olen; i++) begin
            if (span == 0 || span > produced || span > HIST_DEPTH) begin
              store_out(8'h00, 1'b1);
            end else begin
              idx = (wpos + HIST_DEPTH - span) % HIST_DEPTH;
              store_out(hist[idx[HIST_AW-1:0]], 1'b0);
            end
          end
          bit_idx++;
          pick_element();
        end
      endcase
    end
    ending = it.input_last || produced >= cfg_olen;
    if (it.input_last) closed = 1'b1;
    if (n_emit == 0) begin
      if (!ending) return;
      r = '0;
      pending_out.push_back(r);
    end
    r = pending_out.pop_back();
    r.run_last = 1'b1;
    r.stream_end = ending;
    pending_out.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        $error("unexpected transaction: out_byte %0h", out_data.out_byte);
        fail_count++;
      end else begin
        want_out = pending_out.pop_front();
        check_field("out_byte", want_out.out_byte, out_data.out_byte);
        check_field("has_data", {7'd0, want_out.has_data},
                    {7'd0, out_data.has_data});
        check_field("run_last", {7'd0, want_out.run_last},
                    {7'd0, out_data.run_last});
        check_field("stream_end", {7'd0, want_out.stream_end},
                    {7'd0, out_data.stream_end});
        check_field("bad_reference", {7'd0, want_out.bad_reference},
                    {7'd0, out_data.bad_reference});
      end
    end
  end

  initial begin
    int unsigned served, n;
    served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != served) begin
        served = hold_req;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(4, 0) == 0) begin
        n = $urandom_range(3, 1);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st, input logic fin);
    in_t it;
    it.in_byte = b;
    it.stream_start = st;
    it.input_last = fin;
    if (idle_on && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    decode_byte(it);
    if (!ignored_hit) taken_items++;
  endtask

  task automatic send_token(input logic [11:0] code, input logic [3:0] lc, input logic fin);
    send_byte({code[3:0], lc}, 1'b0, 1'b0);
    send_byte(code[11:4], 1'b0, fin);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_regs(input logic [2:0] u, input logic [1:0] bias,
                              input logic [23:0] olen);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNIT_BYTES;
    cfg_data <= {21'd0, u};
    @(posedge clk);
    cfg_unit = u;
    cfg_index <= CFG_LENGTH_BIAS;
    cfg_data <= {22'd0, bias};
    @(posedge clk);
    cfg_bias = bias;
    cfg_index <= CFG_OUTPUT_LENGTH;
    cfg_data <= olen;
    @(posedge clk);
    cfg_olen = olen;
    cfg_we <= 1'b0;
  endtask

  // well-formed stream with random content; bad_pct steers invalid distances
  task automatic random_stream(input int unsigned n_elem, input int unsigned bad_pct,
                               input bit end_mark);
    logic [7:0] flag;
    int unsigned e, k, u, maxc;
    logic [11:0] code;
    logic fin;
    u = unit_of(cfg_unit);
    for (e = 0; e < n_elem; e++) begin
      if (e % 8 == 0) begin
        flag = 8'($urandom);
        send_byte(flag, e == 0, 1'b0);
      end
      fin = end_mark && (e == n_elem - 1);
      if (flag[e % 8]) begin
        for (k = 0; k < u; k++) send_byte(8'($urandom), 1'b0, fin && (k == u - 1));
      end else begin
        maxc = produced / u;
        if (maxc > 4095) maxc = 4095;
        if (maxc == 0 || $urandom_range(99, 0) < bad_pct) begin
          if (maxc == 4095 || $urandom_range(1, 0) == 0) code = 12'd0;
          else code = 12'($urandom_range(4095, maxc + 1));
        end else begin
          code = 12'($urandom_range(maxc, 1));
        end
        send_token(code, 4'($urandom_range(15, 0)), fin);
      end
    end
  endtask

  task automatic test_literal_extremes();
    program_regs(3'd1, 2'd2, OLEN_MAX);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_match_references();
    send_byte(8'h12, 1'b1, 1'b0);
    send_token(12'd0, 4'd0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b0);
    send_token(12'd5, 4'd1, 1'b0);
    send_token(12'd1, 4'd15, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_end_without_data();
    send_byte(8'h00, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_wide_unit_long_match();
    int unsigned k;
    program_regs(3'd7, 2'd3, OLEN_MAX);
    send_byte(8'h01, 1'b1, 1'b0);
    for (k = 0; k < 4; k++) send_byte(8'($urandom), 1'b0, 1'b0);
    send_token(12'd1, 4'd15, 1'b1);
    settle();
  endtask

  task automatic test_length_cutoff();
    program_regs(3'd0, 2'd0, 24'd5);
    send_byte(8'h03, 1'b1, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b0);
    send_token(12'd1, 4'd15, 1'b0);
    send_byte(8'h99, 1'b0, 1'b0);
    settle();
    program_regs(3'd1, 2'd2, 24'd0);
    send_byte(8'hFF, 1'b1, 1'b0);
    settle();
  endtask

  task automatic test_random_streams();
    int unsigned mark;
    program_regs(3'd1, 2'd0, OLEN_MAX);
    mark = taken_items;
    while (taken_items < mark + 30)
      random_stream($urandom_range(20, 4), 10, $urandom_range(1, 0) == 1);
    settle();
  endtask

  task automatic test_backpressure();
    program_regs(3'd2, 2'd1, OLEN_MAX);
    hold_req <= hold_req + 1;
    random_stream(14, 0, 1'b1);
    settle();
  endtask

  task automatic test_length_limit();
    int unsigned mark;
    program_regs(3'd4, 2'd3, 24'($urandom_range(90, 20)));
    mark = taken_items;
    while (taken_items < mark + 15)
      random_stream($urandom_range(14, 6), 15, 1'b0);
    settle();
  endtask

  task automatic test_noise();
    int unsigned mark, k, n;
    program_regs(3'd3, 2'd2, OLEN_MAX);
    mark = taken_items;
    while (taken_items < mark + 12) begin
      random_stream($urandom_range(6, 2), 30, 1'b0);
      n = $urandom_range(6, 2);
      for (k = 0; k < n; k++)
        send_byte(8'($urandom), $urandom_range(5, 0) == 0, $urandom_range(7, 0) == 0);
    end
    settle();
  endtask

  task automatic test_steady_flow();
    int unsigned mark;
    idle_on = 1'b0;
    program_regs(3'd6, 2'd2, OLEN_MAX);
    mark = taken_items;
    while (taken_items < mark + 20)
      random_stream($urandom_range(16, 6), 5, $urandom_range(1, 0) == 1);
    settle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    fail_count = 0;
    taken_items = 0;
    idle_on = 1'b1;
    wpos = 0;
    produced = 0;
    flags = '0;
    bit_idx = 8;
    dphase = AWAIT_FLAG;
    lit_left = 0;
    tok_lo = '0;
    closed = 1'b0;
    cfg_unit = 3'd1;
    cfg_bias = 2'd2;
    cfg_olen = 24'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_literal_extremes();
    test_match_references();
    test_end_without_data();
    test_wide_unit_long_match();
    test_length_cutoff();
    test_random_streams();
    test_backpressure();
    test_length_limit();
    test_noise();
    test_steady_flow();
    if (pending_out.size() != 0) begin
      $error("%0d expected transactions never arrived", pending_out.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/lzssud_pkg.sv
sv/lzssud_ram.sv
sv/lzssud_cmdq.sv
sv/lzssud_front.sv
sv/lzssud_back.sv
sv/lzss_unit_decompressor.sv
sv/lzssud_checker.sv
tb/sv/tb_lzss_unit_decompressor.sv
